// ===== rtl/smix_pkg.sv =====
// shared types, constants and register map of the sine voice mixer
`default_nettype none
package smix_pkg;
    localparam int VOICES_DEF    = 8;
    localparam int SINE_BITS_DEF = 10;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [2:0] REG_SAMPLE_RATE   = 3'd0;
    localparam logic [2:0] REG_ATTACK_FACTOR = 3'd1;
    localparam logic [2:0] REG_DECAY_FACTOR  = 3'd2;
    localparam logic [2:0] REG_DROP_LEVEL    = 3'd3;
    localparam logic [2:0] REG_OUTPUT_GAIN   = 3'd4;

    localparam logic [17:0] SAMPLE_RATE_RST   = 18'd48000;
    localparam logic [15:0] ATTACK_FACTOR_RST = 16'd65000;
    localparam logic [15:0] DECAY_FACTOR_RST  = 16'd65530;
    localparam logic [16:0] DROP_LEVEL_RST    = 17'd66;
    localparam logic [15:0] OUTPUT_GAIN_RST   = 16'd32;

    localparam logic [16:0] LEVEL_ONE = 17'd65536;
    localparam logic [16:0] SIN_A     = 17'd102934;
    localparam logic [15:0] SIN_B     = 16'd42154;
    localparam logic [12:0] SIN_C     = 13'd4765;

    typedef struct packed {
        logic [31:0] phase;
        logic [31:0] step;
        logic [16:0] attack;
        logic [16:0] decay;
        logic        active;
    } voice_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    typedef struct packed {
        logic clear;
        logic feed;
    } mix_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/smix_if.sv =====
// valid/ready channel interfaces for commands and samples
`default_nettype none
interface smix_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [19:0] frequency;
    modport source (output valid, output command, output frequency, input ready);
    modport sink (input valid, input command, input frequency, output ready);
endinterface

interface smix_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [3:0]         voice_count;
    modport source (output valid, output sample, output voice_count, input ready);
    modport sink (input valid, input sample, input voice_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/smix_cell.sv =====
// one voice cell of the rotating voice chain
`default_nettype none
module smix_cell
    import smix_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire cell_ctl_t ctl,
    input  wire voice_t    neighbor,
    input  wire voice_t    fresh,
    output voice_t         voice
);
    voice_t voice_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_reg <= '0;
        end
        else if (ctl.load)
        begin
            voice_reg <= fresh;
        end
        else if (ctl.shift)
        begin
            voice_reg <= neighbor;
        end
    end

    assign voice = voice_reg;
endmodule
`default_nettype wire

// ===== rtl/smix_div.sv =====
// bit-serial restoring divider for the phase step
`default_nettype none
module smix_div
    import smix_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    input  wire [19:0] freq,
    input  wire [17:0] divisor,
    output logic       done,
    output logic [31:0] quotient
);
    logic [47:0] num_reg;
    logic [17:0] rem_reg;
    logic [31:0] quot_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [18:0] trial;
    logic [18:0] diff;
    logic        ge;

    assign trial = {rem_reg, num_reg[47]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == 6'd1);
            if (start)
            begin
                cnt_reg <= 6'd48;
            end
            else if (cnt_reg != 6'd0)
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= {freq, 28'd0};
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (cnt_reg != 6'd0)
        begin
            num_reg  <= {num_reg[46:0], 1'b0};
            rem_reg  <= ge ? diff[17:0] : trial[17:0];
            quot_reg <= {quot_reg[30:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;
endmodule
`default_nettype wire

// ===== rtl/smix_mix.sv =====
// pipelined sine, envelope and accumulate unit fed one voice a cycle
`default_nettype none
module smix_mix
    import smix_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF,
    parameter int ACC_W = 21
)
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire mix_ctl_t ctl,
    input  wire [31:0]    phase,
    input  wire [16:0]    attack,
    input  wire [16:0]    decay,
    output logic signed [ACC_W-1:0] acc
);
    localparam int PB = SINE_TABLE_BITS - 2;

    logic [SINE_TABLE_BITS-1:0] idx;
    logic [16:0] x_raw;
    logic [16:0] x_in;

    logic [5:0]  v_reg;
    logic [16:0] x0_reg, x1_reg, x2s_reg, x3_reg;
    logic [1:0]  q0_reg, q1_reg, q2_reg, q3_reg;
    logic [16:0] att0_reg, dec0_reg;
    logic [16:0] x2_reg, x2b_reg;
    logic [17:0] amp1_reg, amp2_reg, amp3_reg, amp4_reg;
    logic [15:0] tb_reg;
    logic [16:0] ta_reg;
    logic [14:0] smag_reg;
    logic        neg4_reg, neg5_reg;
    logic [17:0] mag_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic [33:0] x_sq;
    logic [34:0] amp_prod;
    logic [29:0] c_prod;
    logic [33:0] b_prod;
    logic [33:0] a_prod;
    logic [16:0] s_half;
    logic [32:0] m_prod;

    assign idx   = phase[31 -: SINE_TABLE_BITS];
    assign x_raw = 17'(idx[PB-1:0]) << (16 - PB);
    assign x_in  = idx[SINE_TABLE_BITS-2] ? (LEVEL_ONE - x_raw) : x_raw;

    assign x_sq     = x0_reg * x0_reg;
    assign amp_prod = 35'((LEVEL_ONE - att0_reg) * dec0_reg);
    assign c_prod   = 30'(SIN_C * x2_reg);
    assign b_prod   = 34'(tb_reg * x2b_reg);
    assign a_prod   = ta_reg * x3_reg;
    assign s_half   = a_prod[33:17];
    assign m_prod   = smag_reg * amp4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            acc_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[4:0], ctl.feed};
            if (ctl.clear)
            begin
                acc_reg <= '0;
            end
            else if (v_reg[5])
            begin
                acc_reg <= neg5_reg ? acc_reg - ACC_W'(mag_reg) : acc_reg + ACC_W'(mag_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 0: quarter-wave position
        x0_reg   <= x_in;
        q0_reg   <= idx[SINE_TABLE_BITS-1 -: 2];
        att0_reg <= attack;
        dec0_reg <= decay;
        // stage 1: x squared, envelope amplitude
        x2_reg   <= x_sq[32:16];
        x1_reg   <= x0_reg;
        q1_reg   <= q0_reg;
        amp1_reg <= amp_prod[33:16];
        // stage 2: inner polynomial term
        tb_reg   <= SIN_B - 16'(c_prod[29:16]);
        x2b_reg  <= x2_reg;
        x2s_reg  <= x1_reg;
        q2_reg   <= q1_reg;
        amp2_reg <= amp1_reg;
        // stage 3: middle polynomial term
        ta_reg   <= SIN_A - 17'(b_prod[33:16]);
        x3_reg   <= x2s_reg;
        q3_reg   <= q2_reg;
        amp3_reg <= amp2_reg;
        // stage 4: sine magnitude, clipped to full scale
        smag_reg <= (s_half > 17'd32767) ? 15'h7fff : s_half[14:0];
        neg4_reg <= q3_reg[1];
        amp4_reg <= amp3_reg;
        // stage 5: weighted term
        mag_reg  <= {1'b0, m_prod[32:16]};
        neg5_reg <= neg4_reg;
    end

    assign acc = acc_reg;
endmodule
`default_nettype wire

// ===== rtl/polyphonic_sine_voice_mixer.sv =====
// top level: voice chain, step divider, mix pipeline, apb registers
//
//  channel  | dir | payload                      | transaction
//  in_ch    | in  | command, frequency           | valid & ready
//  out_ch   | out | sample, voice_count          | valid & ready, ticks only
//  apb      | in  | 5 registers at 4*index       | psel & penable & pwrite
//
// tick: the chain rotates through the mix unit in ST_TICK, the pipeline drains
//   in ST_DRAIN, ST_GAIN applies the gain and ST_DONE issues the sample
// add: 48 bit-serial divide steps, then the divider flags done and ST_ADD
//   writes the new voice into the chain
// remove: the chain shifts toward the head
// reset clears all cells, count and registers to their reset values
// a stalled output holds one sample; the block waits only if a second
//   sample is ready before the first is taken
`default_nettype none
module polyphonic_sine_voice_mixer
    import smix_pkg::*;
#(
    parameter int VOICES          = VOICES_DEF,
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    smix_in_if.sink     in_ch,
    smix_out_if.source  out_ch,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW    = $clog2(VOICES + 1);
    localparam int ACC_W = 17 + $clog2(VOICES + 1);
    localparam int PW    = ACC_W + 17;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_ADD   = 7'b0000100,
        ST_TICK  = 7'b0001000,
        ST_DRAIN = 7'b0010000,
        ST_GAIN  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [17:0] sample_rate_reg;
    logic [15:0] attack_factor_reg;
    logic [15:0] decay_factor_reg;
    logic [16:0] drop_level_reg;
    logic [15:0] output_gain_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg   <= SAMPLE_RATE_RST;
            attack_factor_reg <= ATTACK_FACTOR_RST;
            decay_factor_reg  <= DECAY_FACTOR_RST;
            drop_level_reg    <= DROP_LEVEL_RST;
            output_gain_reg   <= OUTPUT_GAIN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_SAMPLE_RATE:   sample_rate_reg   <= pwdata[17:0];
                REG_ATTACK_FACTOR: attack_factor_reg <= pwdata[15:0];
                REG_DECAY_FACTOR:  decay_factor_reg  <= pwdata[15:0];
                REG_DROP_LEVEL:    drop_level_reg    <= pwdata[16:0];
                REG_OUTPUT_GAIN:   output_gain_reg   <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_SAMPLE_RATE:   prdata = {14'd0, sample_rate_reg};
            REG_ATTACK_FACTOR: prdata = {16'd0, attack_factor_reg};
            REG_DECAY_FACTOR:  prdata = {16'd0, decay_factor_reg};
            REG_DROP_LEVEL:    prdata = {15'd0, drop_level_reg};
            REG_OUTPUT_GAIN:   prdata = {16'd0, output_gain_reg};
            default:           prdata = '0;
        endcase
    end

    // control registers
    logic [CW-1:0] count_reg;
    logic [CW-1:0] rot_reg;
    logic [2:0]    drain_reg;
    logic          in_fire;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    // divider for the phase step of a new voice
    logic        div_start;
    logic        div_done;
    logic [31:0] div_q;

    assign div_start = in_fire && (in_ch.command == CMD_ADD);

    smix_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .freq     (in_ch.frequency),
        .divisor  (sample_rate_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // voice chain: cell 0 holds the oldest voice
    voice_t    cell_q   [VOICES];
    voice_t    cell_nb  [VOICES];
    cell_ctl_t cell_ctl [VOICES];
    voice_t    fresh;
    voice_t    head_upd;
    voice_t    tail_in;
    logic      head_live;
    logic      count_full;
    logic [32:0] att_prod;
    logic [32:0] dec_prod;

    assign count_full = (count_reg == CW'(VOICES));
    assign head_live  = (rot_reg < count_reg) && cell_q[0].active;

    assign fresh.phase  = '0;
    assign fresh.step   = (sample_rate_reg == 18'd0) ? 32'd0 : div_q;
    assign fresh.attack = LEVEL_ONE;
    assign fresh.decay  = LEVEL_ONE;
    assign fresh.active = 1'b1;

    // per-voice advance of phase and envelope levels
    assign att_prod = cell_q[0].attack * attack_factor_reg;
    assign dec_prod = cell_q[0].decay * decay_factor_reg;

    always_comb
    begin
        head_upd = cell_q[0];
        if (head_live)
        begin
            head_upd.phase  = cell_q[0].phase + cell_q[0].step;
            head_upd.attack = att_prod[32:16];
            head_upd.decay  = dec_prod[32:16];
            head_upd.active = (dec_prod[32:16] >= drop_level_reg);
        end
    end

    assign tail_in = (state_reg == ST_TICK) ? head_upd : voice_t'('0);

    logic chain_shift;
    assign chain_shift = (state_reg == ST_TICK)
        || (in_fire && (in_ch.command == CMD_REMOVE) && (count_reg != '0))
        || ((state_reg == ST_ADD) && count_full);

    for (genvar i = 0; i < VOICES; i++)
    begin : g_cell
        if (i == VOICES - 1)
        begin : g_tail
            assign cell_nb[i] = tail_in;
        end
        else
        begin : g_body
            assign cell_nb[i] = cell_q[i + 1];
        end

        assign cell_ctl[i].shift = chain_shift;
        assign cell_ctl[i].load  = (state_reg == ST_ADD)
            && (count_full ? (i == VOICES - 1) : (count_reg == CW'(i)));

        smix_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl[i]),
            .neighbor (cell_nb[i]),
            .fresh    (fresh),
            .voice    (cell_q[i])
        );
    end

    // mix pipeline sees the head cell while the chain rotates
    mix_ctl_t mix_ctl;
    logic signed [ACC_W-1:0] acc;

    assign mix_ctl.clear = in_fire && (in_ch.command == CMD_TICK);
    assign mix_ctl.feed  = (state_reg == ST_TICK) && head_live;

    smix_mix #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .ACC_W           (ACC_W)
    ) u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mix_ctl),
        .phase  (cell_q[0].phase),
        .attack (cell_q[0].attack),
        .decay  (cell_q[0].decay),
        .acc    (acc)
    );

    // gain, truncate toward zero, saturate
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_adj;
    logic signed [PW-1:0] prod_q;
    logic signed [15:0]   sample_sat;

    assign prod_adj = prod_reg + (prod_reg[PW-1] ? PW'(255) : PW'(0));
    assign prod_q   = prod_adj >>> 8;

    always_comb
    begin
        priority if (prod_q > PW'(32767))
        begin
            sample_sat = 16'sh7fff;
        end
        else if (prod_q < -PW'(32768))
        begin
            sample_sat = -16'sh8000;
        end
        else
        begin
            sample_sat = prod_q[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_GAIN)
        begin
            prod_reg <= acc * $signed({1'b0, output_gain_reg});
        end
    end

    // output register
    logic               out_valid_reg;
    logic signed [15:0] sample_reg;
    logic [3:0]         vcount_reg;
    logic               out_load;

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sample_reg <= sample_sat;
            vcount_reg <= 4'(count_reg);
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.sample      = sample_reg;
    assign out_ch.voice_count = vcount_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_ch.command == CMD_ADD))
                begin
                    state_next = ST_DIV;
                end
                else if (in_fire && (in_ch.command == CMD_TICK))
                begin
                    state_next = ST_TICK;
                end
            end
            ST_DIV:   if (div_done) state_next = ST_ADD;
            ST_ADD:   state_next = ST_IDLE;
            ST_TICK:  if (rot_reg == CW'(VOICES - 1)) state_next = ST_DRAIN;
            ST_DRAIN: if (drain_reg == 3'd6) state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rot_reg   <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rot_reg   <= (state_reg == ST_TICK) ? rot_reg + CW'(1) : '0;
            drain_reg <= (state_reg == ST_DRAIN) ? drain_reg + 3'd1 : 3'd0;
            if (in_fire && (in_ch.command == CMD_REMOVE) && (count_reg != '0))
            begin
                count_reg <= count_reg - CW'(1);
            end
            else if ((state_reg == ST_ADD) && !count_full)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(VOICES))
        else $error("voice count above capacity");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("sample issued outside the done state");

    a_feed_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        mix_ctl.feed |-> (state_reg == ST_TICK) && (rot_reg < count_reg))
        else $error("mix unit fed outside a listed voice");
endmodule
`default_nettype wire
